// ===== rtl/pso_pkg.sv =====
package pso_pkg;

    localparam int DIMENSIONS_DEF     = 64;
    localparam int MAX_TOPOLOGIES_DEF = 2;

    localparam int OP_W      = 2;
    localparam int ELEM_W    = 6;
    localparam int DATA_W    = 32;
    localparam int RAND_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = 2 * (DATA_W + 1);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_VEL   = 2'd1,
        OP_POS   = 2'd2,
        OP_SCORE = 2'd3
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_COG_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOPO_GAIN_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOPO_GAIN_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOPO_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_MIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_MAX    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_MIN    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_MAX    = 3'd7;

    typedef struct packed {
        op_t                      op;
        logic [ELEM_W-1:0]        element;
        logic                     in_range;
        logic signed [DATA_W-1:0] inertia;
        logic [RAND_W-1:0]        rand_own;
        logic [RAND_W-1:0]        rand_topo_a;
        logic [RAND_W-1:0]        rand_topo_b;
        logic signed [DATA_W-1:0] best_topo_a;
        logic signed [DATA_W-1:0] best_topo_b;
        logic signed [DATA_W-1:0] init_position;
        logic signed [DATA_W-1:0] init_velocity;
        logic signed [DATA_W-1:0] score;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] cognitive_gain;
        logic signed [DATA_W-1:0] topology_gain_a;
        logic signed [DATA_W-1:0] topology_gain_b;
        logic [1:0]               topology_count;
        logic signed [DATA_W-1:0] vel_min;
        logic signed [DATA_W-1:0] vel_max;
        logic signed [DATA_W-1:0] pos_min;
        logic signed [DATA_W-1:0] pos_max;
    } cfg_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[DATA_W] != v[DATA_W-1]) begin
            r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // floor by 16 bits, then saturate to 32 bits
    function automatic logic signed [DATA_W-1:0] floor_sat(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [DATA_W-1:0] r;
        if ((&p[PROD_W-1:DATA_W+15]) || !(|p[PROD_W-1:DATA_W+15])) begin
            r = p[DATA_W+15:16];
        end else begin
            r = p[PROD_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

    // upper limit first, so the lower limit wins when they cross
    function automatic logic signed [DATA_W-1:0] clamp(
        input logic signed [DATA_W-1:0] v,
        input logic signed [DATA_W-1:0] lo,
        input logic signed [DATA_W-1:0] hi
    );
        logic signed [DATA_W-1:0] r;
        r = v;
        if (r > hi) begin
            r = hi;
        end
        if (r < lo) begin
            r = lo;
        end
        return r;
    endfunction

endpackage

// ===== rtl/pso_front.sv =====
module pso_front import pso_pkg::*; #(
    parameter int DIMENSIONS = DIMENSIONS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [OP_W-1:0]          s_operation,
    input  logic [ELEM_W-1:0]        s_element,
    input  logic signed [DATA_W-1:0] s_inertia,
    input  logic [RAND_W-1:0]        s_rand_own,
    input  logic [RAND_W-1:0]        s_rand_topo_a,
    input  logic [RAND_W-1:0]        s_rand_topo_b,
    input  logic signed [DATA_W-1:0] s_best_topo_a,
    input  logic signed [DATA_W-1:0] s_best_topo_b,
    input  logic signed [DATA_W-1:0] s_init_position,
    input  logic signed [DATA_W-1:0] s_init_velocity,
    input  logic signed [DATA_W-1:0] s_score,
    output head_t                    head,
    input  logic                     pop
);

    item_t      q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    item_t      item_in;
    logic       push;

    always_comb begin
        item_in.op            = op_t'(s_operation);
        item_in.element       = s_element;
        item_in.in_range      = 32'(s_element) < 32'(DIMENSIONS);
        item_in.inertia       = s_inertia;
        item_in.rand_own      = s_rand_own;
        item_in.rand_topo_a   = s_rand_topo_a;
        item_in.rand_topo_b   = s_rand_topo_b;
        item_in.best_topo_a   = s_best_topo_a;
        item_in.best_topo_b   = s_best_topo_b;
        item_in.init_position = s_init_position;
        item_in.init_velocity = s_init_velocity;
        item_in.score         = s_score;
    end

    assign s_ready    = count_reg != 2'd2;
    assign push       = s_valid && s_ready;
    assign head.valid = count_reg != 2'd0;
    assign head.item  = q_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/pso_exec.sv =====
module pso_exec import pso_pkg::*; #(
    parameter int DIMENSIONS     = DIMENSIONS_DEF,
    parameter int MAX_TOPOLOGIES = MAX_TOPOLOGIES_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cfg_t                     cfg,
    input  head_t                    head,
    output logic                     pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [ELEM_W-1:0]        m_element_out,
    output logic signed [DATA_W-1:0] m_element_value,
    output logic                     m_best_improved,
    output logic signed [DATA_W-1:0] m_best_score_out
);

    localparam int AW       = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
    localparam int CW       = $clog2(DIMENSIONS + 1);
    localparam int TOPO_CAP = (MAX_TOPOLOGIES < 2) ? MAX_TOPOLOGIES : 2;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_READ  = 10'b0000000010,
        ST_INIT  = 10'b0000000100,
        ST_MULW  = 10'b0000001000,
        ST_WGT   = 10'b0000010000,
        ST_MULD  = 10'b0000100000,
        ST_ACC   = 10'b0001000000,
        ST_CLAMP = 10'b0010000000,
        ST_COPY  = 10'b0100000000,
        ST_FIN   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [DATA_W-1:0] pos_mem [DIMENSIONS];
    logic [DATA_W-1:0] vel_mem [DIMENSIONS];
    logic [DATA_W-1:0] pb_mem  [DIMENSIONS];

    item_t                     cur_reg;
    logic signed [DATA_W-1:0]  rd_pos_reg, rd_vel_reg, rd_pb_reg;
    logic signed [DATA_W-1:0]  acc_reg, wgt_reg, diff_reg, value_reg, best_reg;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic [1:0]                term_reg;
    logic                      improved_reg;
    logic [CW-1:0]             cnt_reg;
    logic                      cp_wr_reg;
    logic [AW-1:0]             cp_addr_reg;
    logic [ELEM_W-1:0]         out_elem_reg;
    logic signed [DATA_W-1:0]  out_value_reg, out_best_reg;
    logic                      out_improved_reg;
    logic                      out_valid_reg;

    logic [AW-1:0]            raddr, head_addr, cur_addr;
    logic [1:0]               terms_used;
    logic                     out_free, beats;
    logic signed [DATA_W:0]   mul_a, mul_b;
    logic signed [DATA_W-1:0] gain_sel, target_sel, pos_new, vel_new, term_val;
    logic [RAND_W-1:0]        rand_sel;

    assign head_addr  = AW'(head.item.element);
    assign cur_addr   = AW'(cur_reg.element);
    assign terms_used = (cfg.topology_count > 2'(TOPO_CAP)) ? 2'(TOPO_CAP) : cfg.topology_count;
    assign out_free   = !out_valid_reg || m_ready;
    assign beats      = head.item.score > best_reg;
    assign pos_new    = clamp(sat32({rd_pos_reg[DATA_W-1], rd_pos_reg}
                                  + {rd_vel_reg[DATA_W-1], rd_vel_reg}),
                              cfg.pos_min, cfg.pos_max);
    assign vel_new    = clamp(acc_reg, cfg.vel_min, cfg.vel_max);
    assign term_val   = floor_sat(prod_reg);

    always_comb begin
        unique case (term_reg)
            2'd0: begin
                gain_sel   = cfg.cognitive_gain;
                rand_sel   = cur_reg.rand_own;
                target_sel = rd_pb_reg;
            end
            2'd1: begin
                gain_sel   = cfg.topology_gain_a;
                rand_sel   = cur_reg.rand_topo_a;
                target_sel = cur_reg.best_topo_a;
            end
            default: begin
                gain_sel   = cfg.topology_gain_b;
                rand_sel   = cur_reg.rand_topo_b;
                target_sel = cur_reg.best_topo_b;
            end
        endcase
    end

    // one shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_READ) begin
            mul_a = {cur_reg.inertia[DATA_W-1], cur_reg.inertia};
            mul_b = {rd_vel_reg[DATA_W-1], rd_vel_reg};
        end else if (state_reg == ST_MULW) begin
            mul_a = {gain_sel[DATA_W-1], gain_sel};
            mul_b = {{(DATA_W+1-RAND_W){1'b0}}, rand_sel};
        end else if (state_reg == ST_MULD) begin
            mul_a = {wgt_reg[DATA_W-1], wgt_reg};
            mul_b = {diff_reg[DATA_W-1], diff_reg};
        end
    end

    assign prod_next = mul_a * mul_b;

    always_comb begin
        unique case (state_reg)
            ST_IDLE:  raddr = head_addr;
            ST_COPY:  raddr = cnt_reg[AW-1:0];
            default:  raddr = cur_addr;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (head.valid) begin
                    pop = 1'b1;
                    unique case (head.item.op)
                        OP_LOAD:  state_next = ST_FIN;
                        OP_SCORE: state_next = beats ? ST_COPY : ST_FIN;
                        default:  state_next = head.item.in_range ? ST_READ : ST_FIN;
                    endcase
                end
            end
            ST_READ:  state_next = (cur_reg.op == OP_VEL) ? ST_INIT : ST_FIN;
            ST_INIT:  state_next = ST_MULW;
            ST_MULW:  state_next = ST_WGT;
            ST_WGT:   state_next = ST_MULD;
            ST_MULD:  state_next = ST_ACC;
            ST_ACC:   state_next = (term_reg == terms_used) ? ST_CLAMP : ST_MULW;
            ST_CLAMP: state_next = ST_FIN;
            ST_COPY:  state_next = (cnt_reg < CW'(DIMENSIONS)) ? ST_COPY : ST_FIN;
            ST_FIN:   state_next = out_free ? ST_IDLE : ST_FIN;
            default:  state_next = ST_IDLE;
        endcase
    end

    // memories
    always_ff @(posedge aclk) begin
        rd_pos_reg <= pos_mem[raddr];
        rd_vel_reg <= vel_mem[raddr];
        rd_pb_reg  <= pb_mem[raddr];
        if (pop && head.item.op == OP_LOAD && head.item.in_range) begin
            pos_mem[head_addr] <= head.item.init_position;
            vel_mem[head_addr] <= head.item.init_velocity;
        end else if (state_reg == ST_READ && cur_reg.op == OP_POS) begin
            pos_mem[cur_addr] <= pos_new;
        end else if (state_reg == ST_CLAMP) begin
            vel_mem[cur_addr] <= vel_new;
        end
        if (pop && head.item.op == OP_LOAD && head.item.in_range) begin
            pb_mem[head_addr] <= head.item.init_position;
        end else if (cp_wr_reg) begin
            pb_mem[cp_addr_reg] <= rd_pos_reg;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (pop) begin
            cur_reg      <= head.item;
            value_reg    <= (head.item.op == OP_LOAD && head.item.in_range)
                            ? head.item.init_position : '0;
            improved_reg <= (head.item.op == OP_SCORE) && beats;
            cnt_reg      <= '0;
        end
        unique case (state_reg)
            ST_READ: begin
                if (cur_reg.op == OP_POS) begin
                    value_reg <= pos_new;
                end
            end
            ST_INIT: begin
                acc_reg  <= term_val;
                term_reg <= 2'd0;
            end
            ST_WGT: begin
                wgt_reg  <= prod_reg[DATA_W+15:16];
                diff_reg <= sat32({target_sel[DATA_W-1], target_sel}
                                  - {rd_pos_reg[DATA_W-1], rd_pos_reg});
            end
            ST_ACC: begin
                acc_reg  <= sat32({acc_reg[DATA_W-1], acc_reg} + {term_val[DATA_W-1], term_val});
                term_reg <= term_reg + 2'd1;
            end
            ST_CLAMP: value_reg <= vel_new;
            ST_COPY: begin
                if (cnt_reg < CW'(DIMENSIONS)) begin
                    cp_addr_reg <= cnt_reg[AW-1:0];
                    cnt_reg     <= cnt_reg + CW'(1);
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    out_elem_reg     <= cur_reg.element;
                    out_value_reg    <= value_reg;
                    out_improved_reg <= improved_reg;
                    out_best_reg     <= best_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            best_reg      <= '0;
            cp_wr_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (pop && head.item.op == OP_SCORE && beats) begin
                best_reg <= head.item.score;
            end
            cp_wr_reg <= (state_reg == ST_COPY) && (cnt_reg < CW'(DIMENSIONS));
            if (state_reg == ST_FIN && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_element_out    = out_elem_reg;
    assign m_element_value  = out_value_reg;
    assign m_best_improved  = out_improved_reg;
    assign m_best_score_out = out_best_reg;

endmodule

// ===== rtl/pso_particle_update.sv =====
// Channel   Handshake              Word
// s_        s_valid / s_ready      one operation on one element
// m_        m_valid / m_ready      one result per accepted word
// cfg_      cfg_valid / cfg_ready  register index and write data
//
// The back end takes one word off the queue at a time and finishes it before taking the next.
// Load, out-of-range and non-improving score words go straight to the result; a position update reads first.
// A velocity update accumulates the inertia, cognitive and topology terms through one shared multiplier.
// A score that beats the best copies the position vector, element by element.
// Reset clears the control state and the best score; vectors are undefined until loaded.
// A two-word queue takes words while the back end works; s_ready drops when both are full,
// and a held result (m_ready low) stalls the back end in its last cycle.
module pso_particle_update import pso_pkg::*; #(
    parameter int DIMENSIONS     = DIMENSIONS_DEF,
    parameter int MAX_TOPOLOGIES = MAX_TOPOLOGIES_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [OP_W-1:0]          s_operation,
    input  logic [ELEM_W-1:0]        s_element,
    input  logic signed [DATA_W-1:0] s_inertia,
    input  logic [RAND_W-1:0]        s_rand_own,
    input  logic [RAND_W-1:0]        s_rand_topo_a,
    input  logic [RAND_W-1:0]        s_rand_topo_b,
    input  logic signed [DATA_W-1:0] s_best_topo_a,
    input  logic signed [DATA_W-1:0] s_best_topo_b,
    input  logic signed [DATA_W-1:0] s_init_position,
    input  logic signed [DATA_W-1:0] s_init_velocity,
    input  logic signed [DATA_W-1:0] s_score,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [ELEM_W-1:0]        m_element_out,
    output logic signed [DATA_W-1:0] m_element_value,
    output logic                     m_best_improved,
    output logic signed [DATA_W-1:0] m_best_score_out
);

    cfg_t  cfg_reg;
    head_t head;
    logic  pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cognitive_gain  <= 32'sd131072;
            cfg_reg.topology_gain_a <= 32'sd131072;
            cfg_reg.topology_gain_b <= 32'sd131072;
            cfg_reg.topology_count  <= 2'd1;
            cfg_reg.vel_min         <= -32'sd65536;
            cfg_reg.vel_max         <= 32'sd65536;
            cfg_reg.pos_min         <= -32'sd655360;
            cfg_reg.pos_max         <= 32'sd655360;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_COG_GAIN:    cfg_reg.cognitive_gain  <= cfg_data;
                CFG_TOPO_GAIN_A: cfg_reg.topology_gain_a <= cfg_data;
                CFG_TOPO_GAIN_B: cfg_reg.topology_gain_b <= cfg_data;
                CFG_TOPO_COUNT:  cfg_reg.topology_count  <= cfg_data[1:0];
                CFG_VEL_MIN:     cfg_reg.vel_min         <= cfg_data;
                CFG_VEL_MAX:     cfg_reg.vel_max         <= cfg_data;
                CFG_POS_MIN:     cfg_reg.pos_min         <= cfg_data;
                CFG_POS_MAX:     cfg_reg.pos_max         <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    pso_front #(
        .DIMENSIONS(DIMENSIONS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_element       (s_element),
        .s_inertia       (s_inertia),
        .s_rand_own      (s_rand_own),
        .s_rand_topo_a   (s_rand_topo_a),
        .s_rand_topo_b   (s_rand_topo_b),
        .s_best_topo_a   (s_best_topo_a),
        .s_best_topo_b   (s_best_topo_b),
        .s_init_position (s_init_position),
        .s_init_velocity (s_init_velocity),
        .s_score         (s_score),
        .head            (head),
        .pop             (pop)
    );

    pso_exec #(
        .DIMENSIONS     (DIMENSIONS),
        .MAX_TOPOLOGIES (MAX_TOPOLOGIES)
    ) u_exec (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .head             (head),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_element_out    (m_element_out),
        .m_element_value  (m_element_value),
        .m_best_improved  (m_best_improved),
        .m_best_score_out (m_best_score_out)
    );

endmodule
